@@ hw/rtl/qte_pkg.sv @@
package qte_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int QUEUE_DEPTH      = 4;

   localparam int DW  = 16;  // quaternion / angle field width
   localparam int OPW = 34;  // CORDIC operand width at the queue
   localparam int NW  = 44;  // CORDIC datapath width after normalization
   localparam int NL  = 40;  // normalization target bit
   localparam int ZW  = 28;  // Q.24 angle accumulator
   localparam int QW  = 29;  // isqrt result bits
   localparam int VW  = 57;  // isqrt radicand bits

   localparam logic signed [OPW-1:0] ONE_Q28      = OPW'(268435456);
   localparam logic signed [OPW-1:0] NEG_ONE_Q28  = -OPW'(268435456);
   localparam logic        [VW-1:0]  ONE_Q56      = VW'(1) << 56;
   localparam logic signed [ZW-1:0]  HALF_PI_Q24  = ZW'(26353589);
   localparam logic signed [ZW:0]    HALF_LSB     = (ZW+1)'(1024);
   localparam logic signed [ZW-11:0] PI_Q13       = (ZW-10)'(25736);
   localparam logic signed [ZW-11:0] TWO_PI_Q13   = (ZW-10)'(51472);
   localparam logic [14:0]           THR_RESET    = 15'd32735;

   localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   typedef enum logic [1:0] {
      POLE_NONE  = 2'd0,
      POLE_NORTH = 2'd1,
      POLE_SOUTH = 2'd2
   } pole_type;

   typedef struct packed {
      pole_type               pole;
      logic signed [OPW-1:0]  yaw_y;
      logic signed [OPW-1:0]  yaw_x;
      logic signed [OPW-1:0]  pitch_y;
      logic signed [OPW-1:0]  pitch_x;
      logic signed [OPW-1:0]  roll_y;
      logic signed [OPW-1:0]  roll_x;
   } item_type;

   // Q.24 -> Q3.13 with round half up, then wrap into (-pi, pi]
   function automatic logic signed [DW-1:0] to_out(input logic signed [ZW:0] q);
      logic signed [ZW:0]    s;
      logic signed [ZW-11:0] r;
      s = q + HALF_LSB;
      r = s[ZW:11];
      if (r > PI_Q13) begin
         r = r - TWO_PI_Q13;
      end
      if (r <= -PI_Q13) begin
         r = r + TWO_PI_Q13;
      end
      return r[DW-1:0];
   endfunction

endpackage

@@ hw/rtl/quaternion_to_euler_angles_top.sv @@
// Quaternion to yaw / pitch / roll converter.
// req channel: one quaternion per transaction, tdata = {z, y, x, w}, each
//   signed Q2.14, w in the low 16 bits.
// rsp channel: one result per transaction, tdata = {roll, pitch, yaw}, each
//   signed Q3.13 radians in (-pi, pi], yaw in the low 16 bits; tuser carries
//   the pole code (regular, north pole, south pole).
// csr channel: writes the 15-bit pole threshold (Q0.16); always ready.
//   Write it only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while rsp_tready is high.
// Path: an accepted item passes the 34 front stages (products, pole test,
//   29-stage isqrt), is written into the queue, then passes the three
//   CORDIC lanes and the output register.
// Reset: synchronous; clears all valid state and loads threshold 0.4995.
// Back pressure: a held result with rsp_tready low stalls the back; the
//   front keeps accepting until the queue fills, then req_tready drops.
module quaternion_to_euler_angles_top #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data,      // pole_threshold
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // quat_w, quat_x, quat_y, quat_z
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,     // yaw_angle, pitch_angle, roll_angle
   output logic [1:0]  rsp_tuser      // pole_case
);

   localparam int IW = $bits(qte_pkg::item_type);

   logic [14:0]       thr_ff, thr_in;
   logic              q_push, q_full, q_pop, q_empty;
   qte_pkg::item_type push_item, pop_item;
   logic [IW-1:0]     pop_bits;
   qte_pkg::pole_type out_pole;

   assign csr_ready = 1'b1;
   assign thr_in    = (csr_valid && csr_ready) ? csr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= qte_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // front: products, pole test, asin radicand and isqrt
   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_w      ($signed(req_tdata[15:0])),
      .in_x      ($signed(req_tdata[31:16])),
      .in_y      ($signed(req_tdata[47:32])),
      .in_z      ($signed(req_tdata[63:48])),
      .thr       (thr_ff),
      .full      (q_full),
      .push      (q_push),
      .push_item (push_item)
   );

   // decouples the front from output stalls
   qte_fifo #(
      .WIDTH (IW),
      .DEPTH (qte_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_bits),
      .empty     (q_empty)
   );

   assign pop_item = qte_pkg::item_type'(pop_bits);

   // back: three CORDIC lanes and the output register
   qte_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .item      (pop_item),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_yaw   (rsp_tdata[15:0]),
      .out_pitch (rsp_tdata[31:16]),
      .out_roll  (rsp_tdata[47:32]),
      .out_pole  (out_pole)
   );

   assign rsp_tuser = out_pole;

endmodule

@@ hw/rtl/qte_fifo.sv @@
module qte_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/qte_front.sv @@
module qte_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [15:0]       in_w,
   input  logic signed [15:0]       in_x,
   input  logic signed [15:0]       in_y,
   input  logic signed [15:0]       in_z,
   input  logic [14:0]              thr,
   input  logic                     full,
   output logic                     push,
   output qte_pkg::item_type        push_item
);

   localparam int QW  = qte_pkg::QW;
   localparam int VW  = qte_pkg::VW;
   localparam int OPW = qte_pkg::OPW;
   localparam int FL  = 5 + QW;

   typedef struct packed {
      logic signed [31:0] ww, xx, yy, zz, xw, yz, wy, zx, wz, xy;
      logic signed [15:0] x, y;
   } s1_type;

   typedef struct packed {
      logic signed [33:0] unit;
      logic signed [32:0] test;
      logic signed [33:0] yaw_y, yaw_x, roll_y, roll_x, t;
      logic signed [15:0] x, y;
   } s2_type;

   typedef struct packed {
      logic signed [49:0] lhs, rhs;
      logic signed [29:0] tc;
      logic        [28:0] a;
      logic signed [33:0] yaw_y, yaw_x, roll_y, roll_x;
      logic signed [15:0] x, y;
   } s3_type;

   typedef struct packed {
      logic [VW-1:0]     aa;
      qte_pkg::item_type item;
   } s4_type;

   logic              en;
   logic [FL-1:0]     v_ff, v_in;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;
   s4_type            s4_ff, s4_in;

   logic [VW-1:0]     sq_rem_ff  [QW+1];
   logic [VW-1:0]     sq_rem_in  [QW+1];
   logic [QW-1:0]     sq_root_ff [QW+1];
   logic [QW-1:0]     sq_root_in [QW+1];
   qte_pkg::item_type sq_item_ff [QW+1];
   qte_pkg::item_type sq_item_in [QW+1];

   assign en       = !(v_ff[FL-1] && full);
   assign in_ready = en;
   assign push     = v_ff[FL-1] && !full;
   assign v_in     = {v_ff[FL-2:0], in_valid};

   // products
   always_comb begin
      s1_in.ww = in_w * in_w;
      s1_in.xx = in_x * in_x;
      s1_in.yy = in_y * in_y;
      s1_in.zz = in_z * in_z;
      s1_in.xw = in_x * in_w;
      s1_in.yz = in_y * in_z;
      s1_in.wy = in_w * in_y;
      s1_in.zx = in_z * in_x;
      s1_in.wz = in_w * in_z;
      s1_in.xy = in_x * in_y;
      s1_in.x  = in_x;
      s1_in.y  = in_y;
   end

   // sums
   always_comb begin
      s2_in.unit   = 34'(s1_ff.ww) + 34'(s1_ff.xx) + 34'(s1_ff.yy) + 34'(s1_ff.zz);
      s2_in.test   = 33'(s1_ff.xw) - 33'(s1_ff.yz);
      s2_in.yaw_y  = (34'(s1_ff.wy) + 34'(s1_ff.zx)) <<< 1;
      s2_in.yaw_x  = qte_pkg::ONE_Q28 - ((34'(s1_ff.xx) + 34'(s1_ff.yy)) <<< 1);
      s2_in.roll_y = (34'(s1_ff.wz) + 34'(s1_ff.xy)) <<< 1;
      s2_in.roll_x = qte_pkg::ONE_Q28 - ((34'(s1_ff.zz) + 34'(s1_ff.xx)) <<< 1);
      s2_in.t      = (34'(s1_ff.xw) - 34'(s1_ff.yz)) <<< 1;
      s2_in.x      = s1_ff.x;
      s2_in.y      = s1_ff.y;
   end

   // threshold product, asin clamp
   always_comb begin
      s3_in.rhs = $signed({1'b0, thr}) * s2_ff.unit;
      s3_in.lhs = 50'(s2_ff.test) <<< 16;
      priority if (s2_ff.t > qte_pkg::ONE_Q28) begin
         s3_in.tc = 30'(qte_pkg::ONE_Q28);
      end else if (s2_ff.t < qte_pkg::NEG_ONE_Q28) begin
         s3_in.tc = 30'(qte_pkg::NEG_ONE_Q28);
      end else begin
         s3_in.tc = 30'(s2_ff.t);
      end
      s3_in.a      = (s3_in.tc < 0) ? 29'(-s3_in.tc) : 29'(s3_in.tc);
      s3_in.yaw_y  = s2_ff.yaw_y;
      s3_in.yaw_x  = s2_ff.yaw_x;
      s3_in.roll_y = s2_ff.roll_y;
      s3_in.roll_x = s2_ff.roll_x;
      s3_in.x      = s2_ff.x;
      s3_in.y      = s2_ff.y;
   end

   // pole classification
   always_comb begin
      s4_in.aa = VW'(s3_ff.a) * VW'(s3_ff.a);
      priority if (s3_ff.lhs > s3_ff.rhs) begin
         s4_in.item.pole = qte_pkg::POLE_NORTH;
      end else if (s3_ff.lhs < -s3_ff.rhs) begin
         s4_in.item.pole = qte_pkg::POLE_SOUTH;
      end else begin
         s4_in.item.pole = qte_pkg::POLE_NONE;
      end
      if (s4_in.item.pole == qte_pkg::POLE_NONE) begin
         s4_in.item.yaw_y = s3_ff.yaw_y;
         s4_in.item.yaw_x = s3_ff.yaw_x;
      end else begin
         s4_in.item.yaw_y = OPW'(s3_ff.y);
         s4_in.item.yaw_x = OPW'(s3_ff.x);
      end
      s4_in.item.pitch_y = OPW'(s3_ff.tc);
      s4_in.item.pitch_x = '0;
      s4_in.item.roll_y  = s3_ff.roll_y;
      s4_in.item.roll_x  = s3_ff.roll_x;
   end

   // isqrt(1 - t^2), one result bit per stage
   assign sq_rem_in[0]  = qte_pkg::ONE_Q56 - s4_ff.aa;
   assign sq_root_in[0] = '0;
   assign sq_item_in[0] = s4_ff.item;

   for (genvar k = 0; k < QW; k++) begin : g_sq
      localparam int BI = QW - 1 - k;
      logic [VW+1:0] dlt;
      logic          take;
      assign dlt  = ((VW+2)'(sq_root_ff[k]) << (BI + 1)) + ((VW+2)'(1) << (2 * BI));
      assign take = {2'b00, sq_rem_ff[k]} >= dlt;
      assign sq_rem_in[k+1]  = take ? sq_rem_ff[k] - dlt[VW-1:0] : sq_rem_ff[k];
      assign sq_root_in[k+1] = take ? (sq_root_ff[k] | (QW'(1) << BI)) : sq_root_ff[k];
      assign sq_item_in[k+1] = sq_item_ff[k];
   end

   always_comb begin
      push_item         = sq_item_ff[QW];
      push_item.pitch_x = OPW'(sq_root_ff[QW]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_item_ff <= sq_item_in;
      end
   end

endmodule

@@ hw/rtl/qte_cordic.sv @@
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [qte_pkg::OPW-1:0]   in_y,
   input  logic signed [qte_pkg::OPW-1:0]   in_x,
   output logic signed [qte_pkg::ZW-1:0]    out_z
);

   localparam int NW = qte_pkg::NW;
   localparam int ZW = qte_pkg::ZW;
   localparam int NL = qte_pkg::NL;
   localparam int LD = 7 + STEPS;

   logic signed [NW-1:0] cx_ff [LD];
   logic signed [NW-1:0] cx_in [LD];
   logic signed [NW-1:0] cy_ff [LD];
   logic signed [NW-1:0] cy_in [LD];
   logic signed [ZW-1:0] cz_ff [LD];
   logic signed [ZW-1:0] cz_in [LD];
   logic                 zr_ff [LD];
   logic                 zr_in [LD];
   logic [NW-1:0]        m_ff  [6];
   logic [NW-1:0]        m_in  [6];

   logic signed [NW-1:0] xe, ye, px, py;
   logic signed [ZW-1:0] pz;
   logic [NW-1:0]        ay;

   // quadrant fold into the right half plane
   always_comb begin
      xe = NW'(in_x);
      ye = NW'(in_y);
      if (xe < 0) begin
         if (ye >= 0) begin
            px = ye;
            py = -xe;
            pz = qte_pkg::HALF_PI_Q24;
         end else begin
            px = -ye;
            py = xe;
            pz = -qte_pkg::HALF_PI_Q24;
         end
      end else begin
         px = xe;
         py = ye;
         pz = '0;
      end
      ay = (py < 0) ? NW'(-py) : NW'(py);
   end

   assign cx_in[0] = px;
   assign cy_in[0] = py;
   assign cz_in[0] = pz;
   assign zr_in[0] = (in_x == '0) && (in_y == '0);
   assign m_in[0]  = (NW'(px) > ay) ? NW'(px) : ay;

   // normalize: bring the larger magnitude up to at least bit NL
   for (genvar j = 0; j < 6; j++) begin : g_norm
      localparam int SH = 32 >> j;
      logic shf;
      assign shf         = (m_ff[j] >> (NL + 1 - SH)) == '0;
      assign cx_in[j+1]  = shf ? cx_ff[j] <<< SH : cx_ff[j];
      assign cy_in[j+1]  = shf ? cy_ff[j] <<< SH : cy_ff[j];
      assign cz_in[j+1]  = cz_ff[j];
      assign zr_in[j+1]  = zr_ff[j];
      if (j < 5) begin : g_m
         assign m_in[j+1] = shf ? m_ff[j] << SH : m_ff[j];
      end
   end

   // vectoring iterations
   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic                 pos;
      logic signed [NW-1:0] xs, ys;
      assign pos = cy_ff[6+i] > 0;
      assign xs  = cx_ff[6+i] >>> i;
      assign ys  = cy_ff[6+i] >>> i;
      assign cx_in[7+i] = pos ? cx_ff[6+i] + ys : cx_ff[6+i] - ys;
      assign cy_in[7+i] = pos ? cy_ff[6+i] - xs : cy_ff[6+i] + xs;
      assign cz_in[7+i] = pos ? cz_ff[6+i] + qte_pkg::ATAN_TAB[i]
                              : cz_ff[6+i] - qte_pkg::ATAN_TAB[i];
      assign zr_in[7+i] = zr_ff[6+i];
   end

   assign out_z = zr_ff[LD-1] ? '0 : cz_ff[LD-1];

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         zr_ff <= zr_in;
         m_ff  <= m_in;
      end
   end

endmodule

@@ hw/rtl/qte_back.sv @@
module qte_back #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  qte_pkg::item_type      item,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [15:0]            out_yaw,
   output logic [15:0]            out_pitch,
   output logic [15:0]            out_roll,
   output qte_pkg::pole_type      out_pole
);

   localparam int L  = 7 + STEPS;
   localparam int ZW = qte_pkg::ZW;

   logic                  en;
   logic [L-1:0]          vb_ff, vb_in;
   qte_pkg::pole_type     pole_ff [L];
   qte_pkg::pole_type     pole_in [L];
   logic signed [ZW-1:0]  z_yaw, z_pitch, z_roll;
   logic signed [ZW:0]    yq, pq, rq;
   logic                  ov_ff;
   logic [15:0]           yaw_ff, yaw_in, pitch_ff, pitch_in, roll_ff, roll_in;
   qte_pkg::pole_type     opole_ff;

   assign en    = !ov_ff || out_ready;
   assign pop   = en && !empty;
   assign vb_in = {vb_ff[L-2:0], pop};

   assign pole_in[0] = item.pole;
   for (genvar s = 1; s < L; s++) begin : g_pole
      assign pole_in[s] = pole_ff[s-1];
   end

   qte_cordic #(.STEPS(STEPS)) u_yaw (
      .clock (clock),
      .en    (en),
      .in_y  (item.yaw_y),
      .in_x  (item.yaw_x),
      .out_z (z_yaw)
   );

   qte_cordic #(.STEPS(STEPS)) u_pitch (
      .clock (clock),
      .en    (en),
      .in_y  (item.pitch_y),
      .in_x  (item.pitch_x),
      .out_z (z_pitch)
   );

   qte_cordic #(.STEPS(STEPS)) u_roll (
      .clock (clock),
      .en    (en),
      .in_y  (item.roll_y),
      .in_x  (item.roll_x),
      .out_z (z_roll)
   );

   always_comb begin
      unique case (pole_ff[L-1])
         qte_pkg::POLE_NORTH: begin
            yq = (ZW+1)'(z_yaw) <<< 1;
            pq = (ZW+1)'(qte_pkg::HALF_PI_Q24);
            rq = '0;
         end
         qte_pkg::POLE_SOUTH: begin
            yq = -((ZW+1)'(z_yaw) <<< 1);
            pq = -(ZW+1)'(qte_pkg::HALF_PI_Q24);
            rq = '0;
         end
         default: begin
            yq = (ZW+1)'(z_yaw);
            pq = (ZW+1)'(z_pitch);
            rq = (ZW+1)'(z_roll);
         end
      endcase
      yaw_in   = qte_pkg::to_out(yq);
      pitch_in = qte_pkg::to_out(pq);
      roll_in  = qte_pkg::to_out(rq);
   end

   assign out_valid = ov_ff;
   assign out_yaw   = yaw_ff;
   assign out_pitch = pitch_ff;
   assign out_roll  = roll_ff;
   assign out_pole  = opole_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= vb_in;
         ov_ff <= vb_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pole_ff  <= pole_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
         opole_ff <= pole_ff[L-1];
      end
   end

endmodule

@@ tb/quaternion_to_euler_angles_top_tb.sv @@
module quaternion_to_euler_angles_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = qte_pkg::CORDIC_STEPS_DEF;
   localparam int LATENCY = 42 + STEPS;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint NORM_LIM = 64'sd1099511627776;
   localparam longint ONE28 = 64'sd268435456;
   localparam longint HALFPI = 64'sd26353589;

   typedef struct packed {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] yaw, pitch, roll;
      qte_pkg::pole_type  pole;
   } euler_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [14:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // quat_w, quat_x, quat_y, quat_z (low to high)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // yaw_angle, pitch_angle, roll_angle (low to high)
   logic [1:0]  rsp_tuser;         // pole_case

   quaternion_to_euler_angles_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state: the threshold register as the block should hold it
   logic [14:0] thr_model = qte_pkg::THR_RESET;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   int        mismatches = 0;
   longint    cycles = 0;
   bit        stim_done = 1'b0;
   int        hold_off = 0;       // long receiver stall, cycles left

   // ---------------- predictor ----------------
   function automatic longint sra(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan2_q24(longint y, longint x);
      longint z, t, m, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALFPI;
         end else begin
            t = x; x = -y; y = t; z = -HALFPI;
         end
      end
      m = (x < 0 ? -x : x);
      if ((y < 0 ? -y : y) > m) m = (y < 0 ? -y : y);
      while (m < NORM_LIM) begin
         m = m * 2; x = x * 2; y = y * 2;
      end
      for (int i = 0; i < STEPS && i < qte_pkg::ATAN_LEN; i++) begin
         xs = sra(x, i);
         ys = sra(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + longint'(qte_pkg::ATAN_TAB[i]);
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(qte_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint asin_q24(longint t);
      longint unsigned a;
      if (t > ONE28) t = ONE28;
      if (t < -ONE28) t = -ONE28;
      a = t < 0 ? -t : t;
      return atan2_q24(t, longint'(root64((64'd1 << 56) - a * a)));
   endfunction

   function automatic logic signed [15:0] angle_q13(longint q);
      longint r;
      r = (q + 1024) >>> 11;
      if (r > 25736) r = r - 51472;
      if (r <= -25736) r = r + 51472;
      return r[15:0];
   endfunction

   function automatic euler_type quat_to_euler(quat_type q);
      longint w, x, y, z, nrm, lhs, rhs;
      euler_type e;
      w = q.w; x = q.x; y = q.y; z = q.z;
      nrm = w*w + x*x + y*y + z*z;
      lhs = (x*w - y*z) * 65536;
      rhs = longint'(thr_model) * nrm;
      if (lhs > rhs) begin
         e.yaw = angle_q13(2 * atan2_q24(y, x));
         e.pitch = angle_q13(HALFPI);
         e.roll = '0;
         e.pole = qte_pkg::POLE_NORTH;
      end else if (lhs < -rhs) begin
         e.yaw = angle_q13(-2 * atan2_q24(y, x));
         e.pitch = angle_q13(-HALFPI);
         e.roll = '0;
         e.pole = qte_pkg::POLE_SOUTH;
      end else begin
         e.yaw = angle_q13(atan2_q24(2*(w*y + z*x), ONE28 - 2*(x*x + y*y)));
         e.pitch = angle_q13(asin_q24(2*(w*x - y*z)));
         e.roll = angle_q13(atan2_q24(2*(w*z + x*y), ONE28 - 2*(z*z + x*x)));
         e.pole = qte_pkg::POLE_NONE;
      end
      return e;
   endfunction

   // ready sampled at the rising edge, used at the following falling edge
   bit req_tready_s = 1'b0;
   always @(posedge clock) req_tready_s <= req_tready;

   // ---------------- driver ----------------
   // Drives at the falling edge; a request is taken at a rising edge with ready high.
   int       req_gap = 0;
   bit       req_taken;
   quat_type req_quat = '0;
   always @(negedge clock) begin
      req_taken = req_tvalid && req_tready_s;
      if (req_taken) begin
         expected_angles.push_back(quat_to_euler(req_quat));
         req_gap = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) req_gap = 0;
      end
      if (req_taken || !req_tvalid) begin
         if (req_gap > 0 || pending_quats.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_tvalid <= 1'b0;
         end else begin
            req_quat = pending_quats.pop_front();
            req_tdata <= {req_quat.z, req_quat.y, req_quat.x, req_quat.w};
            req_tvalid <= 1'b1;
         end
      end
   end

   // ---------------- monitor ----------------
   int rsp_gap = 0;
   always @(posedge clock) begin
      euler_type got, want;
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.yaw = rsp_tdata[15:0];
         got.pitch = rsp_tdata[31:16];
         got.roll = rsp_tdata[47:32];
         got.pole = qte_pkg::pole_type'(rsp_tuser);
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", rsp_tdata);
         end else begin
            want = expected_angles.pop_front();
            if (got.yaw !== want.yaw || got.pitch !== want.pitch ||
                got.roll !== want.roll || got.pole !== want.pole) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp y=%0d p=%0d r=%0d c=%0d got y=%0d p=%0d r=%0d c=%0d",
                           want.yaw, want.pitch, want.roll, want.pole,
                           got.yaw, got.pitch, got.roll, got.pole);
            end
         end
      end
   end

   // receiver stall pattern: random gaps per transaction, plus the long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_gap = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) rsp_gap = 0;
         rsp_tready <= (rsp_gap == 0);
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= (rsp_gap == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [15:0] rnd16();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return $signed(16'($urandom_range(0, 65535)));
         default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      endcase
   endfunction

   // components in [-1, 1], sometimes a quaternion near a pole (x*w ~ +-0.5)
   function automatic quat_type rnd_unit();
      quat_type q;
      int s;
      if ($urandom_range(0, 3) == 0) begin
         s = $urandom_range(0, 1) ? 1 : -1;
         q.w = 16'sd11585 + $signed(16'($urandom_range(0, 60))) - 16'sd30;
         q.x = 16'(s * (11585 + int'($urandom_range(0, 60)) - 30));
         q.y = $signed(16'($urandom_range(0, 200))) - 16'sd100;
         q.z = $signed(16'($urandom_range(0, 200))) - 16'sd100;
      end else begin
         q.w = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         q.x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         q.y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         q.z = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      end
      return q;
   endfunction

   task automatic drain();
      while (pending_quats.size() != 0 || req_tvalid || expected_angles.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_threshold(logic [14:0] v);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      thr_model = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_random(int n);
      quat_type q;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) q = {rnd16(), rnd16(), rnd16(), rnd16()};
         else q = rnd_unit();
         pending_quats.push_back(q);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero, identity, extremes, both poles, negative-x atan2 branches
      pending_quats.push_back('{0, 0, 0, 0});
      pending_quats.push_back('{16384, 0, 0, 0});
      pending_quats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      pending_quats.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
      pending_quats.push_back('{11585, 11585, 0, 0});
      pending_quats.push_back('{11585, -11585, 0, 0});
      pending_quats.push_back('{11585, 11585, 300, -200});
      pending_quats.push_back('{11585, -11585, -300, 200});
      pending_quats.push_back('{0, -16384, 0, 0});
      pending_quats.push_back('{0, -16384, 5, 0});
      pending_quats.push_back('{0, -16384, -5, 0});
      pending_quats.push_back('{0, 0, 16384, 0});
      pending_quats.push_back('{0, 0, 0, 16384});
      pending_quats.push_back('{16384, 16384, 0, 0});   // asin argument past 1
      pending_quats.push_back('{-16384, 16384, 0, 0});  // past -1
      pending_quats.push_back('{8192, 8192, -8192, 8192});
      drain();

      // threshold extremes and a mid value
      write_threshold(15'd0);
      pending_quats.push_back('{16384, 0, 0, 0});
      pending_quats.push_back('{100, 100, 0, 0});
      pending_quats.push_back('{100, -100, 0, 0});
      add_random(100);
      drain();
      write_threshold(15'h7fff);
      add_random(100);
      drain();
      write_threshold(15'd20000);
      add_random(100);
      drain();
      write_threshold(qte_pkg::THR_RESET);

      // long receiver stall while the sender keeps offering, to fill the block
      add_random(150);
      @(negedge clock);
      hold_off = 300;
      drain();
      add_random(250);
      drain();
      stim_done = 1'b1;
   end

   // ---------------- end of run ----------------
   initial begin
      wait (stim_done || cycles >= CYCLE_LIMIT);
      if (!stim_done) begin
         $display("FAIL quaternion_to_euler_angles_top");
      end else if (mismatches == 0) begin
         $display("PASS quaternion_to_euler_angles_top");
      end else begin
         $display("FAIL quaternion_to_euler_angles_top");
      end
      $finish;
   end
endmodule

@@ quaternion_to_euler_angles_top.f @@
hw/rtl/qte_pkg.sv
hw/rtl/qte_fifo.sv
hw/rtl/qte_front.sv
hw/rtl/qte_cordic.sv
hw/rtl/qte_back.sv
hw/rtl/quaternion_to_euler_angles_top.sv
tb/quaternion_to_euler_angles_top_tb.sv
